// File: hw/rtl/dmp_pkg.sv
// Shared types, constants and sequencer states for the deadline-monotonic picker.
package dmp_pkg;

  localparam int unsigned IdW   = 16;
  localparam int unsigned TimeW = 31;

  localparam logic [TimeW-1:0] TimeAllOnes = '1;

  // Transaction kinds on the input channel
  typedef enum logic [1:0] {
    KIND_LOAD_READY = 2'd0,
    KIND_LOAD_PEND  = 2'd1,
    KIND_DECIDE     = 2'd2,
    KIND_NONE       = 2'd3
  } kind_t;

  // One ready-table entry
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] per;
    logic [TimeW-1:0] dl;
    logic [TimeW-1:0] rem;
  } ready_ent_t;

  // One pending-table entry
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] per;
    logic [TimeW-1:0] rel;
  } pend_ent_t;

  localparam int unsigned ReadyEntW = $bits(ready_ent_t);
  localparam int unsigned PendEntW  = $bits(pend_ent_t);

  // Result of the shared compare/subtract unit
  typedef struct packed {
    logic             lt;
    logic             eq;
    logic [TimeW-1:0] diff;
  } cmp_res_t;

  // Decide sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_MINP,
    S_DLSET,
    S_DLP,
    S_PEND,
    S_CAP,
    S_OUT
  } seq_state_t;

endpackage

// File: hw/rtl/dmp_tbl.sv
// Table memory: one write port, one read port with registered read data.
module dmp_tbl
  import dmp_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/dmp_cmp.sv
// Shared compare and saturating-subtract unit on time values.
module dmp_cmp
  import dmp_pkg::*;
(
  input  logic [TimeW-1:0] op_a,
  input  logic [TimeW-1:0] op_b,
  output cmp_res_t         res
);

  logic [TimeW:0] sub;

  // one subtractor gives a < b from its borrow, and max(0, a - b)
  always_comb begin
    sub      = {1'b0, op_a} - {1'b0, op_b};
    res.lt   = sub[TimeW];
    res.eq   = (op_a == op_b);
    res.diff = sub[TimeW] ? '0 : sub[TimeW-1:0];
  end

endmodule

// File: hw/rtl/deadline_monotonic_picker.sv
// Top level: task tables, decide sequencer around one shared compare unit, output register.
//
//  channel | ports                                        | dir | handshake
//  --------+----------------------------------------------+-----+-----------------
//  in      | in_kind in_thread_id in_period in_deadline   | in  | in_valid/in_stall
//          | in_remaining in_release_time in_now          |     |
//  out     | out_selected_id out_idle out_missed out_slice| out | out_valid/out_stall
//
// Load transactions are taken while no decide runs. A decide transaction walks the
// ready table twice (minimum period, then overdue tasks) and the pending table once
// through the shared compare unit, one entry per cycle, with in_stall high throughout.
// A miss skips the pending walk and the cap step; an empty ready table runs only the
// pending walk and output.
// Reset (rst_n, synchronous) empties both tables and the output register.
// A finished result waits in the output register while loads are taken; the next
// decide waits in its last step until that register is free.
module deadline_monotonic_picker
  import dmp_pkg::*;
#(
  parameter int unsigned READY_DEPTH   = 16,
  parameter int unsigned PENDING_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_kind,
  input  logic [IdW-1:0]   in_thread_id,
  input  logic [TimeW-1:0] in_period,
  input  logic [TimeW-1:0] in_deadline,
  input  logic [TimeW-1:0] in_remaining,
  input  logic [TimeW-1:0] in_release_time,
  input  logic [TimeW-1:0] in_now,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [IdW-1:0]   out_selected_id,
  output logic             out_idle,
  output logic             out_missed,
  output logic [TimeW-1:0] out_slice
);

  localparam int unsigned RAW = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
  localparam int unsigned PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned RCW = $clog2(READY_DEPTH + 1);
  localparam int unsigned PCW = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned IXW = (RCW > PCW) ? RCW : PCW;
  localparam logic [RCW-1:0] RFull = RCW'(READY_DEPTH);
  localparam logic [PCW-1:0] PFull = PCW'(PENDING_DEPTH);

  seq_state_t state_r, state_nxt;

  logic [RCW-1:0]   ready_cnt_r, ready_cnt_nxt;
  logic [PCW-1:0]   pend_cnt_r, pend_cnt_nxt;
  logic [IXW-1:0]   idx_r, idx_nxt;
  logic             pvld_r, pvld_nxt;
  logic             pfirst_r, pfirst_nxt;
  ready_ent_t       sel_r, sel_nxt;
  logic             sel_lt_r, sel_lt_nxt;
  logic             sel_gt_r, sel_gt_nxt;
  logic             missed_r, missed_nxt;
  logic             idle_r, idle_nxt;
  logic [TimeW-1:0] slice_r, slice_nxt;
  logic [TimeW-1:0] now_r, now_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [IdW-1:0]   out_id_r, out_id_nxt;
  logic             out_idle_r, out_idle_nxt;
  logic             out_missed_r, out_missed_nxt;
  logic [TimeW-1:0] out_slice_r, out_slice_nxt;

  logic             in_acc;
  kind_t            kind;
  logic             ready_we, pend_we;
  logic [ReadyEntW-1:0] ready_rd_bits;
  logic [PendEntW-1:0]  pend_rd_bits;
  ready_ent_t       rd_ent;
  pend_ent_t        pd_ent;
  logic [IXW-1:0]   pass_cnt;
  logic             issue;
  logic             pass_done;
  logic             out_free;
  logic [TimeW-1:0] op_a, op_b;
  cmp_res_t         cres;
  logic             pend_prio;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign kind     = kind_t'(in_kind);
  assign out_free = !out_valid_r || !out_stall;

  assign ready_we = in_acc && (kind == KIND_LOAD_READY) && (ready_cnt_r != RFull);
  assign pend_we  = in_acc && (kind == KIND_LOAD_PEND) && (pend_cnt_r != PFull);

  // tables
  dmp_tbl #(.DEPTH(READY_DEPTH), .WIDTH(ReadyEntW)) u_ready_tbl (
    .clk     (clk),
    .wr_en   (ready_we),
    .wr_addr (ready_cnt_r[RAW-1:0]),
    .wr_data (ready_ent_t'{id: in_thread_id, per: in_period,
                           dl: in_deadline, rem: in_remaining}),
    .rd_addr (idx_r[RAW-1:0]),
    .rd_data (ready_rd_bits)
  );

  dmp_tbl #(.DEPTH(PENDING_DEPTH), .WIDTH(PendEntW)) u_pend_tbl (
    .clk     (clk),
    .wr_en   (pend_we),
    .wr_addr (pend_cnt_r[PAW-1:0]),
    .wr_data (pend_ent_t'{id: in_thread_id, per: in_period, rel: in_release_time}),
    .rd_addr (idx_r[PAW-1:0]),
    .rd_data (pend_rd_bits)
  );

  assign rd_ent = ready_ent_t'(ready_rd_bits);
  assign pd_ent = pend_ent_t'(pend_rd_bits);

  // walk control: one read issued per cycle while below the table count
  assign pass_cnt  = (state_r == S_PEND) ? IXW'(pend_cnt_r) : IXW'(ready_cnt_r);
  assign issue     = (idx_r < pass_cnt);
  assign pass_done = !issue;

  // shared compare unit operand select
  always_comb begin
    op_a = now_r;
    op_b = now_r;
    unique case (state_r)
      S_MINP:  begin op_a = rd_ent.per; op_b = sel_r.per; end
      S_DLSET: begin op_a = now_r;      op_b = sel_r.dl;  end
      S_DLP:   begin op_a = now_r;      op_b = rd_ent.dl; end
      S_PEND:  begin op_a = pd_ent.rel; op_b = now_r;     end
      S_CAP:   begin op_a = sel_r.dl;   op_b = now_r;     end
      default: begin op_a = now_r;      op_b = now_r;     end
    endcase
  end

  dmp_cmp u_cmp (
    .op_a (op_a),
    .op_b (op_b),
    .res  (cres)
  );

  // pending task outranks the pick: smaller period, or same period and lower id
  assign pend_prio = (pd_ent.per < sel_r.per) ||
                     ((pd_ent.per == sel_r.per) && (pd_ent.id < sel_r.id));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (kind == KIND_DECIDE)) begin
          state_nxt = (ready_cnt_r == '0) ? S_PEND : S_MINP;
        end
      end
      S_MINP:  if (pass_done) state_nxt = S_DLSET;
      S_DLSET: state_nxt = S_DLP;
      S_DLP: begin
        if (pass_done) begin
          // a replacement in this last cycle also counts as a miss
          state_nxt = missed_nxt ? S_OUT : S_PEND;
        end
      end
      S_PEND:  if (pass_done) state_nxt = idle_r ? S_OUT : S_CAP;
      S_CAP:   state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and counters
  always_comb begin
    ready_cnt_nxt  = ready_cnt_r;
    pend_cnt_nxt   = pend_cnt_r;
    idx_nxt        = idx_r;
    pvld_nxt       = 1'b0;
    pfirst_nxt     = 1'b0;
    sel_nxt        = sel_r;
    sel_lt_nxt     = sel_lt_r;
    sel_gt_nxt     = sel_gt_r;
    missed_nxt     = missed_r;
    idle_nxt       = idle_r;
    slice_nxt      = slice_r;
    now_nxt        = now_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_id_nxt     = out_id_r;
    out_idle_nxt   = out_idle_r;
    out_missed_nxt = out_missed_r;
    out_slice_nxt  = out_slice_r;

    unique case (state_r)
      S_IDLE: begin
        if (ready_we) ready_cnt_nxt = ready_cnt_r + RCW'(1);
        if (pend_we)  pend_cnt_nxt  = pend_cnt_r + PCW'(1);
        if (in_acc && (kind == KIND_DECIDE)) begin
          now_nxt    = in_now;
          idx_nxt    = '0;
          missed_nxt = 1'b0;
          idle_nxt   = (ready_cnt_r == '0);
          slice_nxt  = TimeAllOnes;
        end
      end
      S_MINP: begin
        if (issue) begin
          idx_nxt    = idx_r + IXW'(1);
          pvld_nxt   = 1'b1;
          pfirst_nxt = (idx_r == '0);
        end
        // smallest period, lower id on ties
        if (pvld_r && (pfirst_r || cres.lt || (cres.eq && (rd_ent.id < sel_r.id)))) begin
          sel_nxt = rd_ent;
        end
        if (pass_done) idx_nxt = '0;
      end
      S_DLSET: begin
        sel_lt_nxt = cres.lt;
        sel_gt_nxt = !cres.lt && !cres.eq;
      end
      S_DLP: begin
        if (issue) begin
          idx_nxt  = idx_r + IXW'(1);
          pvld_nxt = 1'b1;
        end
        // overdue task takes over a pick not yet due, or a past-deadline pick with no lower id
        if (pvld_r && !cres.lt &&
            (sel_lt_r || (sel_gt_r && (rd_ent.id <= sel_r.id)))) begin
          sel_nxt    = rd_ent;
          missed_nxt = 1'b1;
          sel_lt_nxt = 1'b0;
          sel_gt_nxt = !cres.eq;
        end
        if (pass_done) begin
          idx_nxt   = '0;
          slice_nxt = missed_nxt ? '0 : sel_nxt.rem;
        end
      end
      S_PEND: begin
        if (issue) begin
          idx_nxt  = idx_r + IXW'(1);
          pvld_nxt = 1'b1;
        end
        // cut at the earliest release that outranks the pick
        if (pvld_r && (idle_r || pend_prio) && (cres.diff < slice_r)) begin
          slice_nxt = cres.diff;
        end
      end
      S_CAP: begin
        // cap at the deadline
        if (cres.diff < slice_r) slice_nxt = cres.diff;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_id_nxt     = idle_r ? '0 : sel_r.id;
          out_idle_nxt   = idle_r;
          out_missed_nxt = missed_r;
          out_slice_nxt  = slice_r;
          ready_cnt_nxt  = '0;
          pend_cnt_nxt   = '0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ready_cnt_r <= '0;
      pend_cnt_r  <= '0;
      idx_r       <= '0;
      pvld_r      <= 1'b0;
      pfirst_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ready_cnt_r <= ready_cnt_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      idx_r       <= idx_nxt;
      pvld_r      <= pvld_nxt;
      pfirst_r    <= pfirst_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sel_r        <= sel_nxt;
    sel_lt_r     <= sel_lt_nxt;
    sel_gt_r     <= sel_gt_nxt;
    missed_r     <= missed_nxt;
    idle_r       <= idle_nxt;
    slice_r      <= slice_nxt;
    now_r        <= now_nxt;
    out_id_r     <= out_id_nxt;
    out_idle_r   <= out_idle_nxt;
    out_missed_r <= out_missed_nxt;
    out_slice_r  <= out_slice_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_selected_id = out_id_r;
  assign out_idle        = out_idle_r;
  assign out_missed      = out_missed_r;
  assign out_slice       = out_slice_r;

  // checks
  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_idle |-> (out_selected_id == '0) && !out_missed)
    else $error("idle result carries a task");

  a_missed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_missed |-> (out_slice == '0))
    else $error("missed task got a nonzero slice");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MINP || state_r == S_DLP) |-> (idx_r <= IXW'(ready_cnt_r)))
    else $error("ready walk ran past the table count");

  a_tables_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && out_free |=> (ready_cnt_r == '0) && (pend_cnt_r == '0))
    else $error("tables not cleared after decide");

endmodule
